// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file swrc_checker.sv.
// Each macro expects signals named clk and rst in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define SWRC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every clock edge, reset included.
`define SWRC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/swrc_pkg.sv =====
// ----------------------------------------------------------------------------
// Swept rectangle collision test - shared definitions
// Widths, corner and edge codes, datapath types and range-check helpers.
// ----------------------------------------------------------------------------
package swrc_pkg;

  localparam int FRAC_BITS = 4;
  localparam int CW = 16;        // coordinate and velocity
  localparam int SZW = 12;       // size in whole units
  localparam int HW = SZW - 1 + FRAC_BITS + 1;  // half size, signed
  localparam int PW = 2 * CW;    // one product
  localparam int OW = 20;        // edge offset along the velocity axis
  localparam int XW = PW + 2;    // cross product of velocity with a point
  localparam int NW = XW + 1;    // numerator and denominator
  localparam int NC = 4;         // corners of the moving rectangle
  localparam int NE = 4;         // edges of the static rectangle
  localparam int NP = NC * NE;   // segment pairs

  // Corner k of a rectangle: bit set where the half size is subtracted.
  // Order: left-top, right-top, right-bottom, left-bottom.
  localparam logic [NC-1:0] CORNER_XNEG = 4'b1001;
  localparam logic [NC-1:0] CORNER_YNEG = 4'b0011;

  // Edge e starts at static corner e. Horizontal edges sit at even codes.
  // Edges 1 and 2, set in EDGE_FLIP, take the negated numerator.
  localparam logic [NE-1:0] EDGE_FLIP = 4'b0110;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [HW-1:0] half_t;
  typedef logic signed [PW-1:0] prod_val_t;
  typedef logic signed [OW-1:0] off_t;
  typedef logic signed [XW-1:0] cross_t;
  typedef logic signed [NW-1:0] num_t;

  typedef struct packed {
    prod_val_t vx_my;
    prod_val_t vy_mx;
    prod_val_t vx_mh;
    prod_val_t vy_mw;
    prod_val_t vx_sy;
    prod_val_t vy_sx;
    prod_val_t vx_sh;
    prod_val_t vy_sw;
  } prod_t;

  typedef struct packed {
    prod_t             prod;
    off_t [NP-1:0]     off;
    coord_t            vx;
    coord_t            vy;
  } stage1_t;

  typedef struct packed {
    cross_t [NE-1:0]   cs;
    cross_t [NC-1:0]   cm;
    num_t              den_w;
    num_t              den_h;
    logic [NP-1:0]     nb_ok;
  } stage2_t;

  typedef struct packed {
    num_t [NP-1:0]     num;
    num_t              den_w;
    num_t              den_h;
    logic [NP-1:0]     nb_ok;
  } stage3_t;

  function automatic logic unit_off(off_t n, off_t d);
    if (d > 0) begin
      return (n >= 0) && (n <= d);
    end
    return (n <= 0) && (n >= d);
  endfunction

  function automatic logic unit_num(num_t n, num_t d);
    if (d > 0) begin
      return (n >= 0) && (n <= d);
    end
    return (n <= 0) && (n >= d);
  endfunction

endpackage

// ===== sv/swept_rect_collision_test.sv =====
// ----------------------------------------------------------------------------
// Swept rectangle collision test
// Sweeps the four corners of a moving rectangle along its velocity and
// reports whether any swept corner crosses an edge of a static rectangle.
//
// Usage:
//   Input channel: in_valid / in_stall with one query per transfer (both
//   centres, both sizes, velocity). Output channel: out_valid / out_stall
//   with one hit flag per transfer, in query order.
//   An input transfer passes through registers s1, s2, s3 and hit to out_valid.
//   Throughput is one query per cycle while the output is not stalled; the
//   four register stages (products, corner cross terms, numerators, range
//   compare and combine) each take a new query every cycle they are not stalled.
//   A stall on the output holds the result and backs up the pipeline one
//   stage at a time; empty stages keep filling, so in_stall rises only when
//   all four stages hold a query and the output is stalled.
//   Reset empties the pipeline; no state survives between queries.
// ----------------------------------------------------------------------------
module swept_rect_collision_test (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [swrc_pkg::CW-1:0]    static_center_x,
  input  logic signed [swrc_pkg::CW-1:0]    static_center_y,
  input  logic        [swrc_pkg::SZW-1:0]   static_width,
  input  logic        [swrc_pkg::SZW-1:0]   static_height,
  input  logic signed [swrc_pkg::CW-1:0]    moving_center_x,
  input  logic signed [swrc_pkg::CW-1:0]    moving_center_y,
  input  logic        [swrc_pkg::SZW-1:0]   moving_width,
  input  logic        [swrc_pkg::SZW-1:0]   moving_height,
  input  logic signed [swrc_pkg::CW-1:0]    velocity_x,
  input  logic signed [swrc_pkg::CW-1:0]    velocity_y,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              hit
);

  localparam int NP = swrc_pkg::NP;
  localparam int NE = swrc_pkg::NE;
  localparam int NC = swrc_pkg::NC;
  localparam int OW = swrc_pkg::OW;
  localparam int PW = swrc_pkg::PW;
  localparam int XW = swrc_pkg::XW;
  localparam int NW = swrc_pkg::NW;
  localparam int FB = swrc_pkg::FRAC_BITS;
  localparam int SZW = swrc_pkg::SZW;

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3, rdy4;

  swrc_pkg::stage1_t s1, s1_next;
  swrc_pkg::stage2_t s2, s2_next;
  swrc_pkg::stage3_t s3, s3_next;
  logic              hit_next;

  swrc_pkg::half_t   shw, shh, mhw, mhh;

  assign rdy4 = !out_valid || !out_stall;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_stall = !rdy1;

  assign shw = signed'({1'b0, static_width[SZW-1:1], {FB{1'b0}}});
  assign shh = signed'({1'b0, static_height[SZW-1:1], {FB{1'b0}}});
  assign mhw = signed'({1'b0, moving_width[SZW-1:1], {FB{1'b0}}});
  assign mhh = signed'({1'b0, moving_height[SZW-1:1], {FB{1'b0}}});

  // Stage 1: velocity products and per-pair offsets along the velocity axis.
  always_comb begin
    swrc_pkg::off_t ey, ex, cy, cx;
    s1_next.prod.vx_my = PW'(velocity_x) * PW'(moving_center_y);
    s1_next.prod.vy_mx = PW'(velocity_y) * PW'(moving_center_x);
    s1_next.prod.vx_mh = PW'(velocity_x) * PW'(mhh);
    s1_next.prod.vy_mw = PW'(velocity_y) * PW'(mhw);
    s1_next.prod.vx_sy = PW'(velocity_x) * PW'(static_center_y);
    s1_next.prod.vy_sx = PW'(velocity_y) * PW'(static_center_x);
    s1_next.prod.vx_sh = PW'(velocity_x) * PW'(shh);
    s1_next.prod.vy_sw = PW'(velocity_y) * PW'(shw);
    s1_next.vx = velocity_x;
    s1_next.vy = velocity_y;
    for (int e = 0; e < NE; e++) begin
      ey = swrc_pkg::CORNER_YNEG[e] ? OW'(static_center_y) - OW'(shh)
                                    : OW'(static_center_y) + OW'(shh);
      ex = swrc_pkg::CORNER_XNEG[e] ? OW'(static_center_x) - OW'(shw)
                                    : OW'(static_center_x) + OW'(shw);
      for (int k = 0; k < NC; k++) begin
        cy = swrc_pkg::CORNER_YNEG[k] ? OW'(moving_center_y) - OW'(mhh)
                                      : OW'(moving_center_y) + OW'(mhh);
        cx = swrc_pkg::CORNER_XNEG[k] ? OW'(moving_center_x) - OW'(mhw)
                                      : OW'(moving_center_x) + OW'(mhw);
        s1_next.off[e*NC+k] = (e % 2 == 0) ? ey - cy : ex - cx;
      end
    end
  end

  // Stage 2: cross product of velocity with every corner, edge parameter test.
  always_comb begin
    for (int e = 0; e < NE; e++) begin
      s2_next.cs[e] = XW'(s1.prod.vx_sy) - XW'(s1.prod.vy_sx)
                    + (swrc_pkg::CORNER_YNEG[e] ? -XW'(s1.prod.vx_sh)
                                                :  XW'(s1.prod.vx_sh))
                    + (swrc_pkg::CORNER_XNEG[e] ?  XW'(s1.prod.vy_sw)
                                                : -XW'(s1.prod.vy_sw));
    end
    for (int k = 0; k < NC; k++) begin
      s2_next.cm[k] = XW'(s1.prod.vx_my) - XW'(s1.prod.vy_mx)
                    + (swrc_pkg::CORNER_YNEG[k] ? -XW'(s1.prod.vx_mh)
                                                :  XW'(s1.prod.vx_mh))
                    + (swrc_pkg::CORNER_XNEG[k] ?  XW'(s1.prod.vy_mw)
                                                : -XW'(s1.prod.vy_mw));
    end
    s2_next.den_w = NW'(s1.prod.vy_sw) + NW'(s1.prod.vy_sw);
    s2_next.den_h = NW'(s1.prod.vx_sh) + NW'(s1.prod.vx_sh);
    for (int p = 0; p < NP; p++) begin
      s2_next.nb_ok[p] = ((p / NC) % 2 == 0) ?
                         swrc_pkg::unit_off(s1.off[p], OW'(s1.vy)) :
                         swrc_pkg::unit_off(s1.off[p], OW'(s1.vx));
    end
  end

  // Stage 3: numerator of the swept-segment parameter for each pair.
  always_comb begin
    s3_next.den_w = s2.den_w;
    s3_next.den_h = s2.den_h;
    s3_next.nb_ok = s2.nb_ok;
    for (int e = 0; e < NE; e++) begin
      for (int k = 0; k < NC; k++) begin
        s3_next.num[e*NC+k] = swrc_pkg::EDGE_FLIP[e] ?
                              NW'(s2.cm[k]) - NW'(s2.cs[e]) :
                              NW'(s2.cs[e]) - NW'(s2.cm[k]);
      end
    end
  end

  // Stage 4: range compare against the denominator and combine.
  always_comb begin
    swrc_pkg::num_t d;
    hit_next = 1'b0;
    for (int p = 0; p < NP; p++) begin
      d = ((p / NC) % 2 == 0) ? s3.den_w : s3.den_h;
      if (s3.nb_ok[p] && (d != 0) && swrc_pkg::unit_num(s3.num[p], d)) begin
        hit_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) s1 <= s1_next;
    if (rdy2) s2 <= s2_next;
    if (rdy3) s3 <= s3_next;
    if (rdy4) hit <= hit_next;
  end

endmodule

// ===== sv/swrc_checker.sv =====
// ----------------------------------------------------------------------------
// Swept rectangle collision test - port checker
// Watches the channel ports of the top level for hold under stall, reset, stall cause and latency.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swrc_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic hit
);

  `SWRC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped under stall")
  `SWRC_ASSERT(a_hit_hold, out_valid && out_stall |=> $stable(hit), "hit changed under stall")
  `SWRC_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result present after reset")
  `SWRC_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall, "input stalled with output free")
  `SWRC_ASSERT(a_latency, (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid, "result late")

endmodule

bind swept_rect_collision_test swrc_checker u_swrc_checker (.*);
